>>> design/imu_frame_parser_defines.svh
// ----------------------------------------------------------------------------
// imu_frame_parser assertion macros
// Concurrent check wrappers clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef IMU_FRAME_PARSER_DEFINES_SVH
`define IMU_FRAME_PARSER_DEFINES_SVH

// same-cycle implication
`define IMU_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define IMU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/imu_pkg.sv
// ----------------------------------------------------------------------------
// imu_pkg
// Shared types and constants of the IMU serial frame parser.
// ----------------------------------------------------------------------------
package imu_pkg;

   localparam int WIN_LEN = 11;

   localparam logic [7:0] SYNC_BYTE  = 8'h55;
   localparam logic [7:0] TYPE_ACC   = 8'h51;
   localparam logic [7:0] TYPE_GYRO  = 8'h52;
   localparam logic [7:0] TYPE_ANGLE = 8'h53;

   localparam logic [3:0] SKIP_AFTER_FRAME = 4'd10;

   localparam int OFS_W = 26;

   localparam logic [1:0] CSR_ROLL  = 2'd0;
   localparam logic [1:0] CSR_PITCH = 2'd1;
   localparam logic [1:0] CSR_YAW   = 2'd2;

   // scale factors to Q16.16 (acceleration is x3136 then /10 rounded)
   localparam logic [31:0] ACC_MUL   = 32'd3136;
   localparam logic [31:0] ACC_ROUND = 32'd5;
   localparam logic [31:0] RATE_MUL  = 32'd4000;
   localparam logic [31:0] ANGLE_MUL = 32'd360;

   // q = (m * DIV10_MAGIC) >> 35, exact for m < 2**32
   localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;

   typedef enum logic [1:0] {
      KIND_ACC   = 2'd0,
      KIND_RATE  = 2'd1,
      KIND_ANGLE = 2'd2,
      KIND_ERR   = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] raw_x;
      logic [15:0] raw_y;
      logic [15:0] raw_z;
   } frame_type;

   typedef struct packed {
      logic      valid;
      frame_type frame;
   } push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   typedef struct packed {
      logic [OFS_W-1:0] roll;
      logic [OFS_W-1:0] pitch;
      logic [OFS_W-1:0] yaw;
   } offsets_type;

endpackage

>>> design/imu_front.sv
// ----------------------------------------------------------------------------
// imu_front
// Byte window, skip counter and checksum check; pushes decoded raw frames.
// ----------------------------------------------------------------------------
module imu_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // rx_byte[7:0]
   input  imu_pkg::qstat_type   qstat,
   output imu_pkg::push_type    push
);

   logic [7:0] win_ff [imu_pkg::WIN_LEN];
   logic [7:0] win_in [imu_pkg::WIN_LEN];
   logic [3:0] skip_ff;
   logic [3:0] skip_in;
   logic       accept;
   logic [7:0] sum_lo;
   logic [7:0] sum_hi;
   logic [7:0] sum;

   assign req_tready = !qstat.full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      for (int i = 0; i < imu_pkg::WIN_LEN - 1; i++) begin
         win_in[i] = win_ff[i+1];
      end
      win_in[imu_pkg::WIN_LEN-1] = req_tdata;
   end

   // checksum over new window bytes 0..9 (old bytes 1..10)
   always_comb begin
      sum_lo = 8'd0;
      sum_hi = 8'd0;
      for (int i = 1; i <= 5; i++) begin
         sum_lo = sum_lo + win_ff[i];
         sum_hi = sum_hi + win_ff[i+5];
      end
      sum = sum_lo + sum_hi;
   end

   always_comb begin
      push.valid       = 1'b0;
      push.frame.kind  = imu_pkg::KIND_ERR;
      push.frame.raw_x = {win_ff[4], win_ff[3]};
      push.frame.raw_y = {win_ff[6], win_ff[5]};
      push.frame.raw_z = {win_ff[8], win_ff[7]};
      skip_in          = skip_ff;
      if (accept) begin
         if (skip_ff != 4'd0) begin
            skip_in = skip_ff - 4'd1;
         end else if (win_ff[1] == imu_pkg::SYNC_BYTE) begin
            if (sum != req_tdata) begin
               push.valid       = 1'b1;
               push.frame.kind  = imu_pkg::KIND_ERR;
               push.frame.raw_x = 16'd0;
               push.frame.raw_y = 16'd0;
               push.frame.raw_z = 16'd0;
            end else begin
               case (win_ff[2])
                  imu_pkg::TYPE_ACC: begin
                     push.valid      = 1'b1;
                     push.frame.kind = imu_pkg::KIND_ACC;
                     skip_in         = imu_pkg::SKIP_AFTER_FRAME;
                  end
                  imu_pkg::TYPE_GYRO: begin
                     push.valid      = 1'b1;
                     push.frame.kind = imu_pkg::KIND_RATE;
                     skip_in         = imu_pkg::SKIP_AFTER_FRAME;
                  end
                  imu_pkg::TYPE_ANGLE: begin
                     push.valid      = 1'b1;
                     push.frame.kind = imu_pkg::KIND_ANGLE;
                     skip_in         = imu_pkg::SKIP_AFTER_FRAME;
                  end
                  default: begin
                     push.valid = 1'b0;
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff <= 4'd0;
         for (int i = 0; i < imu_pkg::WIN_LEN; i++) begin
            win_ff[i] <= 8'd0;
         end
      end else begin
         skip_ff <= skip_in;
         if (accept) begin
            for (int i = 0; i < imu_pkg::WIN_LEN; i++) begin
               win_ff[i] <= win_in[i];
            end
         end
      end
   end

endmodule

>>> design/imu_queue.sv
// ----------------------------------------------------------------------------
// imu_queue
// Small FIFO of raw frames between the front and back parts.
// ----------------------------------------------------------------------------
module imu_queue #(
   parameter int QDEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  imu_pkg::push_type     push,
   input  logic                  pop,
   output imu_pkg::frame_type    head,
   output imu_pkg::qstat_type    qstat
);

   localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int CNT_W = $clog2(QDEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QDEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QDEPTH);

   imu_pkg::frame_type mem_ff [QDEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;

   assign qstat.full  = (count_ff == CNT_FULL);
   assign qstat.empty = (count_ff == '0);
   assign head        = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push.valid, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.frame;
      end
   end

endmodule

>>> design/imu_back.sv
// ----------------------------------------------------------------------------
// imu_back
// Two-stage scaling pipeline to Q16.16 with the result register.
// ----------------------------------------------------------------------------
module imu_back (
   input  logic                  clock,
   input  logic                  reset,
   input  imu_pkg::frame_type    head,
   input  imu_pkg::qstat_type    qstat,
   input  imu_pkg::offsets_type  offsets,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [95:0]           rsp_tdata,  // value_x[31:0], value_y, value_z
   output logic [1:0]            rsp_tuser   // kind[1:0]
);

   logic              v1_ff, v1_in;
   logic              v2_ff, v2_in;
   logic              en1, en2;
   imu_pkg::kind_type kind1_ff, kind1_in;
   logic [31:0]       pre1_ff [3];
   logic [31:0]       pre1_in [3];
   logic [2:0]        neg1_ff, neg1_in;
   logic [1:0]        kind2_ff;
   logic [31:0]       val2_ff [3];
   logic [31:0]       val2_in [3];
   logic [15:0]       raw    [3];
   logic [31:0]       ofs    [3];
   logic [31:0]       raw32  [3];
   logic [16:0]       mag    [3];
   logic [59:0]       prod   [3];
   logic [24:0]       quo    [3];

   assign en2 = !v2_ff || rsp_tready;
   assign en1 = !v1_ff || en2;
   assign pop = !qstat.empty && en1;

   assign v1_in = en1 ? pop : v1_ff;
   assign v2_in = en2 ? v1_ff : v2_ff;

   assign raw[0] = head.raw_x;
   assign raw[1] = head.raw_y;
   assign raw[2] = head.raw_z;
   assign ofs[0] = {{(32-imu_pkg::OFS_W){offsets.roll[imu_pkg::OFS_W-1]}}, offsets.roll};
   assign ofs[1] = {{(32-imu_pkg::OFS_W){offsets.pitch[imu_pkg::OFS_W-1]}}, offsets.pitch};
   assign ofs[2] = {{(32-imu_pkg::OFS_W){offsets.yaw[imu_pkg::OFS_W-1]}}, offsets.yaw};

   // stage 1: constant multiplies, offsets, magnitude for rounding
   always_comb begin
      kind1_in = head.kind;
      for (int a = 0; a < 3; a++) begin
         raw32[a]   = {{16{raw[a][15]}}, raw[a]};
         mag[a]     = raw[a][15] ? (17'd0 - raw32[a][16:0]) : raw32[a][16:0];
         neg1_in[a] = raw[a][15];
         case (head.kind)
            imu_pkg::KIND_ACC:
               pre1_in[a] = {15'd0, mag[a]} * imu_pkg::ACC_MUL + imu_pkg::ACC_ROUND;
            imu_pkg::KIND_RATE:
               pre1_in[a] = raw32[a] * imu_pkg::RATE_MUL;
            imu_pkg::KIND_ANGLE:
               if (a == 2) begin
                  pre1_in[a] = (32'd0 - raw32[a]) * imu_pkg::ANGLE_MUL + ofs[a];
               end else begin
                  pre1_in[a] = raw32[a] * imu_pkg::ANGLE_MUL + ofs[a];
               end
            default:
               pre1_in[a] = 32'd0;
         endcase
      end
   end

   // stage 2: divide by ten for acceleration, restore sign
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         prod[a] = 60'(pre1_ff[a][27:0]) * 60'(imu_pkg::DIV10_MAGIC);
         quo[a]  = prod[a][59:35];
         if (kind1_ff == imu_pkg::KIND_ACC) begin
            val2_in[a] = neg1_ff[a] ? (32'd0 - {7'd0, quo[a]}) : {7'd0, quo[a]};
         end else begin
            val2_in[a] = pre1_ff[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind1_ff <= kind1_in;
         neg1_ff  <= neg1_in;
         for (int a = 0; a < 3; a++) begin
            pre1_ff[a] <= pre1_in[a];
         end
      end
      if (en2 && v1_ff) begin
         kind2_ff <= kind1_ff;
         for (int a = 0; a < 3; a++) begin
            val2_ff[a] <= val2_in[a];
         end
      end
   end

   assign rsp_tvalid = v2_ff;
   assign rsp_tuser  = kind2_ff;
   assign rsp_tdata  = {val2_ff[2], val2_ff[1], val2_ff[0]};

endmodule

>>> design/imu_frame_parser.sv
// ----------------------------------------------------------------------------
// imu_frame_parser: IMU serial frame parser, one byte per item, Q16.16 results.
// Throughput one byte per cycle while the frame queue is not full (req_tready low when full).
// Order: window check on the last byte, frame queue, scale stage, divide stage.
// Reset (synchronous) clears window, skip count, queue, pipeline and offsets.
// ----------------------------------------------------------------------------
`include "imu_frame_parser_defines.svh"

module imu_frame_parser #(
   parameter int QDEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte[7:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // value_x[31:0], value_y[63:32], value_z[95:64]
   output logic [1:0]  rsp_tuser,   // kind[1:0]
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [25:0] csr_wdata
);

   imu_pkg::push_type    push;
   imu_pkg::qstat_type   qstat;
   imu_pkg::frame_type   head;
   imu_pkg::offsets_type ofs_ff;
   imu_pkg::offsets_type ofs_in;
   logic                 pop;

   always_comb begin
      ofs_in = ofs_ff;
      if (csr_we) begin
         case (csr_index)
            imu_pkg::CSR_ROLL:  ofs_in.roll  = csr_wdata;
            imu_pkg::CSR_PITCH: ofs_in.pitch = csr_wdata;
            imu_pkg::CSR_YAW:   ofs_in.yaw   = csr_wdata;
            default:            ofs_in       = ofs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ofs_ff <= '0;
      end else begin
         ofs_ff <= ofs_in;
      end
   end

   imu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .qstat      (qstat),
      .push       (push)
   );

   imu_queue #(
      .QDEPTH (QDEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .qstat (qstat)
   );

   imu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .qstat      (qstat),
      .offsets    (ofs_ff),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   `IMU_ASSERT_SAME(a_err_zero, rsp_tvalid && (rsp_tuser == imu_pkg::KIND_ERR), rsp_tdata == 96'd0, "error item with nonzero data")
   `IMU_ASSERT_SAME(a_pop_nonempty, pop, !qstat.empty, "pop from empty queue")
   `IMU_ASSERT_NEXT(a_push_lands, push.valid && !pop, !qstat.empty, "pushed frame lost")

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the IMU serial frame parser
// Streams bytes into imu_frame_parser: directed frames of every type, bad
// sums, unknown types, offset register extremes, then random frames mixed
// with noise and cut-off frames. A byte-level model of the window, skip
// counter and scaling predicts each result; results are checked in order.
// ----------------------------------------------------------------------------
module tb_top;

   localparam logic [1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      imu_pkg::kind_type kind;
      logic [31:0]       x;
      logic [31:0]       y;
      logic [31:0]       z;
   } imu_sample_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;   // rx_byte[7:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;           // value_x[31:0], value_y[63:32], value_z[95:64]
   logic [1:0]  rsp_tuser;           // kind[1:0]
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_index  = 2'd0;
   logic [25:0] csr_wdata  = 26'd0;

   imu_sample_type pending_samples[$];
   int             mismatch_count = 0;
   int             items_sent     = 0;
   int             send_idle_pct  = 0;
   int             recv_idle_pct  = 0;

   // parser state as seen by the predictor
   logic [7:0]  rx_window[imu_pkg::WIN_LEN];
   logic [3:0]  skip_left = 4'd0;
   logic [25:0] roll_ofs  = 26'd0;
   logic [25:0] pitch_ofs = 26'd0;
   logic [25:0] yaw_ofs   = 26'd0;

   imu_frame_parser i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   initial begin
      #2_000_000;
      $display("tb_top: errors");
      $finish;
   end

   // ---------------------------------------------------------------- predictor
   function automatic logic [31:0] accel_q16(input longint raw);
      longint p;
      p = raw * 3136;
      if (p >= 0) return 32'((p + 5) / 10);
      return 32'(-((-p + 5) / 10));
   endfunction

   task automatic parse_byte(input logic [7:0] rx);
      logic [7:0]     sum;
      longint         rx_x, rx_y, rx_z;
      imu_sample_type s;
      int             k;
      for (k = 0; k < imu_pkg::WIN_LEN - 1; k++) rx_window[k] = rx_window[k + 1];
      rx_window[imu_pkg::WIN_LEN - 1] = rx;
      if (skip_left != 4'd0) begin
         skip_left = skip_left - 4'd1;
         return;
      end
      if (rx_window[0] != imu_pkg::SYNC_BYTE) return;
      sum = 8'd0;
      for (k = 0; k < imu_pkg::WIN_LEN - 1; k++) sum = sum + rx_window[k];
      if (sum != rx_window[imu_pkg::WIN_LEN - 1]) begin
         s = '{imu_pkg::KIND_ERR, 32'd0, 32'd0, 32'd0};
         pending_samples.push_back(s);
         return;
      end
      rx_x = longint'($signed({rx_window[3], rx_window[2]}));
      rx_y = longint'($signed({rx_window[5], rx_window[4]}));
      rx_z = longint'($signed({rx_window[7], rx_window[6]}));
      case (rx_window[1])
         imu_pkg::TYPE_ACC: begin
            s = '{imu_pkg::KIND_ACC, accel_q16(rx_x), accel_q16(rx_y),
                  accel_q16(rx_z)};
         end
         imu_pkg::TYPE_GYRO: begin
            s = '{imu_pkg::KIND_RATE, 32'(rx_x * 4000), 32'(rx_y * 4000),
                  32'(rx_z * 4000)};
         end
         imu_pkg::TYPE_ANGLE: begin
            s.kind = imu_pkg::KIND_ANGLE;
            s.x    = 32'(rx_x * 360 + longint'($signed(roll_ofs)));
            s.y    = 32'(rx_y * 360 + longint'($signed(pitch_ofs)));
            s.z    = 32'(-rx_z * 360 + longint'($signed(yaw_ofs)));
         end
         default: return;
      endcase
      skip_left = imu_pkg::SKIP_AFTER_FRAME;
      pending_samples.push_back(s);
   endtask

   // ---------------------------------------------------------------- checker
   task automatic check_field(input string fname, input logic [31:0] want, got);
      if (got !== want) begin
         $display("%0t: %s expected %h actual %h", $time, fname, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : result_check
      imu_sample_type want;
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_samples.size() == 0) begin
            $display("%0t: unexpected item kind %0d data %h", $time, rsp_tuser, rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_samples.pop_front();
            check_field("kind", {30'd0, want.kind}, {30'd0, rsp_tuser});
            check_field("value_x", want.x, rsp_tdata[31:0]);
            check_field("value_y", want.y, rsp_tdata[63:32]);
            check_field("value_z", want.z, rsp_tdata[95:64]);
         end
      end
   end

   // ---------------------------------------------------------------- drivers
   task automatic send_byte(input logic [7:0] rx);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rx;
      do @(posedge clock); while (!req_tready);
      parse_byte(rx);
      items_sent++;
   endtask

   // sends the first len bytes of a frame
   task automatic send_frame(input logic [7:0] ftype, input logic [15:0] x, y, z,
                             input logic bad_sum, input int len);
      logic [7:0] f[imu_pkg::WIN_LEN];
      logic [7:0] sum;
      int         k;
      f[0] = imu_pkg::SYNC_BYTE;
      f[1] = ftype;
      f[2] = x[7:0];
      f[3] = x[15:8];
      f[4] = y[7:0];
      f[5] = y[15:8];
      f[6] = z[7:0];
      f[7] = z[15:8];
      f[8] = 8'($urandom);
      f[9] = 8'($urandom);
      sum = 8'd0;
      for (k = 0; k < imu_pkg::WIN_LEN - 1; k++) sum = sum + f[k];
      f[10] = bad_sum ? sum + 8'($urandom_range(1, 255)) : sum;
      for (k = 0; k < len; k++) send_byte(f[k]);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [25:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         imu_pkg::CSR_ROLL:  roll_ofs  = val;
         imu_pkg::CSR_PITCH: pitch_ofs = val;
         imu_pkg::CSR_YAW:   yaw_ofs   = val;
         default: ;
      endcase
   endtask

   function automatic logic [15:0] pick_raw();
      case ($urandom_range(15))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [25:0] pick_offset();
      if ($urandom_range(1) == 0) return 26'($urandom_range(47185920) - 23592960);
      return 26'($urandom);
   endfunction

   // ---------------------------------------------------------------- tests
   task automatic test_directed();
      send_idle_pct = 32;
      recv_idle_pct = 73;
      send_frame(imu_pkg::TYPE_ACC, 16'h8000, 16'h7fff, 16'h0000, 1'b0, imu_pkg::WIN_LEN);
      send_frame(imu_pkg::TYPE_ACC, 16'h0001, 16'hffff, 16'h5555, 1'b0, imu_pkg::WIN_LEN);
      send_frame(imu_pkg::TYPE_GYRO, 16'h8000, 16'h7fff, 16'h0001, 1'b0, imu_pkg::WIN_LEN);
      send_frame(imu_pkg::TYPE_ANGLE, 16'h7fff, 16'h8000, 16'hffff, 1'b0, imu_pkg::WIN_LEN);
      send_frame(imu_pkg::TYPE_ACC, 16'h1234, 16'h5678, 16'h9abc, 1'b1, imu_pkg::WIN_LEN);
      // unknown type: no result and no skip, so the next frame is seen
      send_frame(8'h50, 16'h0100, 16'h0200, 16'h0300, 1'b0, imu_pkg::WIN_LEN);
      send_frame(imu_pkg::TYPE_ANGLE, 16'h0000, 16'h0000, 16'h0000, 1'b0, imu_pkg::WIN_LEN);
      send_byte(8'h00);
      send_byte(8'hff);
   endtask

   task automatic test_offsets();
      logic [25:0] ofs;
      int          i;
      for (i = 0; i < 6; i++) begin
         case (i)
            0: ofs = 26'd23592960;
            1: ofs = 26'(-23592960);
            2: ofs = 26'h1ffffff;
            3: ofs = 26'h2000000;
            4: ofs = 26'd0;
            default: ofs = pick_offset();
         endcase
         wait_idle();
         write_reg(imu_pkg::CSR_ROLL, ofs);
         write_reg(imu_pkg::CSR_PITCH, ~ofs);
         write_reg(imu_pkg::CSR_YAW, ofs);
         write_reg(CSR_UNUSED, 26'($urandom));
         send_frame(imu_pkg::TYPE_ANGLE, 16'h7fff, 16'h8000, 16'h8000, 1'b0,
                    imu_pkg::WIN_LEN);
         send_frame(imu_pkg::TYPE_ANGLE, pick_raw(), pick_raw(), pick_raw(), 1'b0,
                    imu_pkg::WIN_LEN);
      end
   endtask

   task automatic test_random_phase(input int s_pct, r_pct, n);
      int         stop_at, r, len;
      logic [7:0] ftype;
      wait_idle();
      write_reg(imu_pkg::CSR_ROLL, pick_offset());
      write_reg(imu_pkg::CSR_PITCH, pick_offset());
      write_reg(imu_pkg::CSR_YAW, pick_offset());
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      stop_at = items_sent + n;
      while (items_sent < stop_at) begin
         r = $urandom_range(99);
         if (r < 8) begin
            len = $urandom_range(1, 15);
            repeat (len)
               send_byte($urandom_range(3) == 0 ? imu_pkg::SYNC_BYTE : 8'($urandom));
         end else if (r < 10) begin
            wait_idle();
         end else begin
            r = $urandom_range(19);
            if (r < 6) ftype = imu_pkg::TYPE_ACC;
            else if (r < 12) ftype = imu_pkg::TYPE_GYRO;
            else if (r < 18) ftype = imu_pkg::TYPE_ANGLE;
            else ftype = 8'($urandom);
            len = ($urandom_range(19) == 0) ? $urandom_range(1, 10) : imu_pkg::WIN_LEN;
            send_frame(ftype, pick_raw(), pick_raw(), pick_raw(),
                       $urandom_range(19) == 0, len);
         end
      end
   endtask

   initial begin
      foreach (rx_window[k]) rx_window[k] = 8'd0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_offsets();
      test_random_phase(32, 73, 446);
      test_random_phase(73, 32, 446);
      test_random_phase(0, 0, 446);
      wait_idle();
      repeat (16) @(posedge clock);
      if (mismatch_count == 0) $display("tb_top: clean");
      else $display("tb_top: errors");
      $finish;
   end

endmodule
